>>> rtl/qbc_pkg.sv
// Shared types, codes and width helpers for the quaternion basis change block.
package qbc_pkg;

  localparam int DATA_W         = 16;
  localparam int FRAC_BITS_DEF  = 14;
  // Quotient bits below the saturation point of a 16-bit signed result
  localparam int QUOT_BITS      = DATA_W - 1;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;

  // Shepperd branch codes: which component is taken from the square root
  localparam logic [1:0] BR_X = 2'd0;
  localparam logic [1:0] BR_Y = 2'd1;
  localparam logic [1:0] BR_Z = 2'd2;
  localparam logic [1:0] BR_W = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
    logic signed [DATA_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_x;
    logic signed [DATA_W-1:0] res_y;
    logic signed [DATA_W-1:0] res_z;
    logic signed [DATA_W-1:0] res_w;
    logic                     bad_root;
  } res_t;

  // Width of matrix entries, sums and root arguments (2*FRAC_BITS fraction bits)
  function automatic int mat_width(int frac);
    return ((2 * frac > 32) ? 2 * frac : 32) + 5;
  endfunction

  // Width of the integer square root of a positive matrix-width value
  function automatic int root_width(int frac);
    return mat_width(frac) / 2;
  endfunction

endpackage

>>> rtl/quaternion_basis_change.sv
// Quaternion basis change: a three-stage pipelined front end feeds a pipelined root and divider.
//
// Takes one rotation quaternion per cycle (Q2.14 at the default FRAC_BITS), forms its
// rotation matrix in the reflected axis frame, and extracts the quaternion again with
// Shepperd's four-branch method. Throughput is one item per clock while res_ready is high.
// From the accepting edge to res_valid an item passes the two front stages after the product
// stage, the queue, RW square-root stages (one root bit each), the divider prep stage, the
// divider stages (one quotient bit each) and the output register; RW = mat_width(FRAC_BITS)/2.
// A two-entry queue sits between the front end and the root/divide pipeline, so the front keeps
// accepting while the output is held, until queue and front end fill. When the chosen branch's
// root argument is not positive, the item returns all zero components with bad_root set.
module quaternion_basis_change #(
  parameter int FRAC_BITS = qbc_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           quat_valid,
  output logic           quat_ready,
  input  qbc_pkg::quat_t quat,
  output logic           res_valid,
  input  logic           res_ready,
  output qbc_pkg::res_t  res
);
  import qbc_pkg::*;

  localparam int MW = mat_width(FRAC_BITS);
  localparam int RW = root_width(FRAC_BITS);
  localparam int EW = 4 * MW + 2;
  localparam int SW = 3 * MW + 3;

  logic          q_push, q_pop, q_full, q_empty, adv, root_valid;
  logic [EW-1:0] f_entry, q_entry;
  logic [RW-1:0] root;
  logic [SW-1:0] side;

  // Back end moves as one pipeline, held only while a result waits
  assign adv   = !res_valid || res_ready;
  assign q_pop = adv && !q_empty;

  qbc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst,
    .quat_valid, .quat_ready, .quat,
    .full  (q_full),
    .push  (q_push),
    .entry (f_entry)
  );

  qbc_queue #(.W(EW)) u_queue (
    .clk, .rst,
    .push  (q_push),
    .din   (f_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_entry),
    .empty (q_empty)
  );

  qbc_root #(.FRAC_BITS(FRAC_BITS)) u_root (
    .clk, .rst,
    .adv,
    .in_valid  (!q_empty),
    .entry     (q_entry),
    .out_valid (root_valid),
    .root,
    .side
  );

  qbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst,
    .adv,
    .in_valid (root_valid),
    .root,
    .side,
    .res_valid,
    .res
  );

  // Queue is never written past capacity nor read while empty
  assert property (@(posedge clk) disable iff (rst) q_full |-> !q_push)
    else $error("queue pushed while full");

  assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // A failed root always returns zero components
  assert property (@(posedge clk) disable iff (rst)
      res_valid && res.bad_root |->
      res.res_x == '0 && res.res_y == '0 && res.res_z == '0 && res.res_w == '0)
    else $error("bad root item carries nonzero components");

endmodule

>>> rtl/qbc_front.sv
// Front end: products, reflected rotation matrix, branch choice, root argument, numerators.
module qbc_front #(
  parameter int FRAC_BITS = qbc_pkg::FRAC_BITS_DEF,
  localparam int MW = qbc_pkg::mat_width(FRAC_BITS),
  localparam int EW = 4 * MW + 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          quat_valid,
  output logic          quat_ready,
  input  qbc_pkg::quat_t quat,
  input  logic          full,
  output logic          push,
  output logic [EW-1:0] entry
);
  import qbc_pkg::*;

  localparam logic signed [MW-1:0] ONE = MW'(1) << (2 * FRAC_BITS);

  // Twice a 32-bit product, sign extended to matrix width
  function automatic logic signed [MW-1:0] t2(logic signed [31:0] p);
    return {{(MW-33){p[31]}}, p, 1'b0};
  endfunction

  logic v1, v2, v3, en;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [MW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic signed [MW-1:0] tr, arg, n0, n1, n2;
  logic [1:0] br;
  logic bad;

  assign en         = !v3 || !full;
  assign quat_ready = en;
  assign push       = v3 && !full;

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= quat_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Stage 1: the nine products
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= quat.quat_x * quat.quat_x;
      yy <= quat.quat_y * quat.quat_y;
      zz <= quat.quat_z * quat.quat_z;
      xy <= quat.quat_x * quat.quat_y;
      xz <= quat.quat_x * quat.quat_z;
      yz <= quat.quat_y * quat.quat_z;
      xw <= quat.quat_x * quat.quat_w;
      yw <= quat.quat_y * quat.quat_w;
      zw <= quat.quat_z * quat.quat_w;
    end
  end

  // Stage 2: rotation matrix in the reflected frame, M = C*R*C^T
  always_ff @(posedge clk) begin
    if (en) begin
      m00 <= ONE - t2(xx) - t2(zz);     // r11
      m11 <= ONE - t2(xx) - t2(yy);     // r22
      m22 <= ONE - t2(yy) - t2(zz);     // r00
      m01 <= t2(yz) - t2(xw);           // r12
      m10 <= t2(yz) + t2(xw);           // r21
      m02 <= -(t2(xy) + t2(zw));        // -r10
      m20 <= -(t2(xy) - t2(zw));        // -r01
      m12 <= -(t2(xz) - t2(yw));        // -r20
      m21 <= -(t2(xz) + t2(yw));        // -r02
    end
  end

  // Stage 3: branch choice, root argument and the three numerators
  assign tr = m00 + m11 + m22;

  always_comb begin
    if (tr > 0) begin
      br  = BR_W;
      arg = ONE + tr;
      n0  = m21 - m12;
      n1  = m02 - m20;
      n2  = m10 - m01;
    end else if (m00 > m11 && m00 > m22) begin
      br  = BR_X;
      arg = ONE + m00 - m11 - m22;
      n0  = m01 + m10;
      n1  = m02 + m20;
      n2  = m21 - m12;
    end else if (m11 > m22) begin
      br  = BR_Y;
      arg = ONE + m11 - m00 - m22;
      n0  = m01 + m10;
      n1  = m12 + m21;
      n2  = m02 - m20;
    end else begin
      br  = BR_Z;
      arg = ONE + m22 - m00 - m11;
      n0  = m02 + m20;
      n1  = m12 + m21;
      n2  = m10 - m01;
    end
    bad = arg[MW-1] || (arg == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      entry <= {br, bad, arg[MW-2:0], n2, n1, n0};
    end
  end

endmodule

>>> rtl/qbc_queue.sv
// Two-entry queue between the front end and the root/divide back end.
module qbc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

endmodule

>>> rtl/qbc_root.sv
// Pipelined integer square root, one root bit per stage, with side data carried along.
module qbc_root #(
  parameter int FRAC_BITS = qbc_pkg::FRAC_BITS_DEF,
  localparam int MW = qbc_pkg::mat_width(FRAC_BITS),
  localparam int RW = qbc_pkg::root_width(FRAC_BITS),
  localparam int EW = 4 * MW + 2,
  localparam int SW = 3 * MW + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [EW-1:0] entry,
  output logic          out_valid,
  output logic [RW-1:0] root,
  output logic [SW-1:0] side
);

  logic          v    [RW];
  logic [RW+1:0] rem  [RW];
  logic [RW-1:0] rt   [RW];
  logic [2*RW-1:0] rest [RW];
  logic [SW-1:0] sd   [RW];

  logic [2*RW-1:0] rest0;
  logic [SW-1:0]   side0;

  // Entry layout: {branch, bad, arg, n2, n1, n0}
  assign rest0 = (2*RW)'(entry[3*MW +: MW-1]);
  assign side0 = {entry[EW-1 -: 3], entry[3*MW-1:0]};

  for (genvar k = 0; k < RW; k++) begin : g_st
    logic          vi;
    logic [RW+1:0] remi;
    logic [RW-1:0] rti;
    logic [2*RW-1:0] resti;
    logic [SW-1:0] sdi;
    logic [RW+3:0] sh, trial;

    if (k == 0) begin : g_first
      assign vi    = in_valid;
      assign remi  = '0;
      assign rti   = '0;
      assign resti = rest0;
      assign sdi   = side0;
    end else begin : g_next
      assign vi    = v[k-1];
      assign remi  = rem[k-1];
      assign rti   = rt[k-1];
      assign resti = rest[k-1];
      assign sdi   = sd[k-1];
    end

    // Bring down two argument bits, try root*4+1
    assign sh    = {remi, resti[2*RW-1 -: 2]};
    assign trial = {2'b00, rti, 2'b01};

    always_ff @(posedge clk) begin
      if (rst)      v[k] <= 1'b0;
      else if (adv) v[k] <= vi;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (sh >= trial) begin
          rem[k] <= (RW+2)'(sh - trial);
          rt[k]  <= {rti[RW-2:0], 1'b1};
        end else begin
          rem[k] <= sh[RW+1:0];
          rt[k]  <= {rti[RW-2:0], 1'b0};
        end
        rest[k] <= resti << 2;
        sd[k]   <= sdi;
      end
    end
  end

  assign out_valid = v[RW-1];
  assign root      = rt[RW-1];
  assign side      = sd[RW-1];

endmodule

>>> rtl/qbc_div.sv
// Pipelined three-lane rounding divider by 2*root, result placement and output register.
module qbc_div #(
  parameter int FRAC_BITS = qbc_pkg::FRAC_BITS_DEF,
  localparam int MW = qbc_pkg::mat_width(FRAC_BITS),
  localparam int RW = qbc_pkg::root_width(FRAC_BITS),
  localparam int SW = 3 * MW + 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [RW-1:0] root,
  input  logic [SW-1:0] side,
  output logic          res_valid,
  output qbc_pkg::res_t res
);
  import qbc_pkg::*;

  localparam int QB = QUOT_BITS;
  localparam int DV = MW + RW + QB;

  logic          v    [QB+1];
  logic [1:0]    br   [QB+1];
  logic          bad  [QB+1];
  logic [QB-1:0] qtr  [QB+1];
  logic [RW:0]   d    [QB+1];
  logic [2:0]    neg  [QB+1];
  logic [2:0]    ovf  [QB+1];
  logic [DV-1:0] rem  [QB+1][3];
  logic [QB-1:0] qv   [QB+1][3];

  logic [RW:0]   qtr_full;
  logic [RW:0]   dpre;
  logic [DV-1:0] num  [3];
  logic [2:0]    negp;
  logic signed [DATA_W-1:0] val [3];
  logic signed [DATA_W-1:0] qsel;
  res_t res_next;

  // Prep: magnitudes plus root for round-to-nearest, overflow check, quarter term
  assign dpre     = {root, 1'b0};
  assign qtr_full = ((RW+1)'(root) + (RW+1)'(1)) >> 1;

  for (genvar i = 0; i < 3; i++) begin : g_prep
    logic signed [MW-1:0] n;
    logic [MW-1:0] mag;
    assign n       = side[i*MW +: MW];
    assign negp[i] = n[MW-1];
    assign mag     = n[MW-1] ? MW'(-n) : MW'(n);
    assign num[i]  = DV'(mag) + DV'(root);
  end

  always_ff @(posedge clk) begin
    if (rst)      v[0] <= 1'b0;
    else if (adv) v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      br[0]  <= side[SW-1 -: 2];
      bad[0] <= side[SW-3];
      d[0]   <= dpre;
      neg[0] <= negp;
      qtr[0] <= (qtr_full > (RW+1)'(DATA_MAX)) ? QB'(DATA_MAX) : qtr_full[QB-1:0];
      for (int i = 0; i < 3; i++) begin
        rem[0][i] <= num[i];
        qv[0][i]  <= '0;
        ovf[0][i] <= num[i] >= (DV'(dpre) << QB);
      end
    end
  end

  // Restoring division, one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_st
    logic [DV-1:0] dsh;
    assign dsh = DV'(d[j-1]) << (QB - j);

    always_ff @(posedge clk) begin
      if (rst)      v[j] <= 1'b0;
      else if (adv) v[j] <= v[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        br[j]  <= br[j-1];
        bad[j] <= bad[j-1];
        d[j]   <= d[j-1];
        neg[j] <= neg[j-1];
        ovf[j] <= ovf[j-1];
        qtr[j] <= qtr[j-1];
        for (int i = 0; i < 3; i++) begin
          if (rem[j-1][i] >= dsh) begin
            rem[j][i] <= rem[j-1][i] - dsh;
            qv[j][i]  <= qv[j-1][i] | (QB'(1) << (QB - j));
          end else begin
            rem[j][i] <= rem[j-1][i];
            qv[j][i]  <= qv[j-1][i];
          end
        end
      end
    end
  end

  // Signed, saturated components and their placement around the root term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ovf[QB][i])     val[i] = neg[QB][i] ? DATA_MIN : DATA_MAX;
      else if (neg[QB][i]) val[i] = -$signed({1'b0, qv[QB][i]});
      else                val[i] = $signed({1'b0, qv[QB][i]});
    end
    qsel = $signed({1'b0, qtr[QB]});
    res_next.bad_root = bad[QB];
    unique case (br[QB])
      BR_X: begin
        res_next.res_x = qsel;   res_next.res_y = val[0];
        res_next.res_z = val[1]; res_next.res_w = val[2];
      end
      BR_Y: begin
        res_next.res_x = val[0]; res_next.res_y = qsel;
        res_next.res_z = val[1]; res_next.res_w = val[2];
      end
      BR_Z: begin
        res_next.res_x = val[0]; res_next.res_y = val[1];
        res_next.res_z = qsel;   res_next.res_w = val[2];
      end
      default: begin
        res_next.res_x = val[0]; res_next.res_y = val[1];
        res_next.res_z = val[2]; res_next.res_w = qsel;
      end
    endcase
    if (bad[QB]) begin
      res_next.res_x = '0;
      res_next.res_y = '0;
      res_next.res_z = '0;
      res_next.res_w = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst)      res_valid <= 1'b0;
    else if (adv) res_valid <= v[QB];
  end

  always_ff @(posedge clk) begin
    if (adv) res <= res_next;
  end

endmodule
